@@ sv/mbk_pkg.sv @@
// Shared types, constants and code tables for the Morse beacon keyer.
`default_nettype none

package mbk_pkg;

  // Message store geometry
  localparam int MSG_DEPTH = 64;
  localparam int MSG_AW    = $clog2(MSG_DEPTH);
  localparam int CNT_W     = $clog2(MSG_DEPTH + 1);
  localparam int LEN_W     = 7;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DOT      = 1'b1;

  localparam int DEBOUNCE_W = 10;
  localparam int DOT_W      = 12;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd50;
  localparam logic [DOT_W-1:0]      DOT_RESET      = 12'd200;

  // Debounce counter saturates here
  localparam int SETTLE_W = 11;
  localparam logic [SETTLE_W-1:0] SETTLE_MAX = 11'd1024;

  // Phase lengths in units
  localparam int UNITS_W = 4;
  localparam logic [UNITS_W-1:0] UNITS_DOT        = 4'd1;
  localparam logic [UNITS_W-1:0] UNITS_DASH       = 4'd3;
  localparam logic [UNITS_W-1:0] UNITS_ELEM_GAP   = 4'd1;
  localparam logic [UNITS_W-1:0] UNITS_LETTER_GAP = 4'd3;
  localparam logic [UNITS_W-1:0] UNITS_WORD_GAP   = 4'd7;
  localparam logic [UNITS_W-1:0] UNITS_REPEAT_GAP = 4'(UNITS_WORD_GAP * 2);

  localparam int TICKS_W = 16;

  // Item kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_CHAR = 1'b1;

  // Characters of interest
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Character classes: 0..25 letters, then space, then anything else
  localparam int CLASS_W = 5;
  localparam logic [CLASS_W-1:0] CLASS_SPACE = 5'd26;
  localparam logic [CLASS_W-1:0] CLASS_OTHER = 5'd27;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_SEND  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_MARK       = 3'd1,
    PH_ELEM_GAP   = 3'd2,
    PH_LETTER_GAP = 3'd3,
    PH_WORD_GAP   = 3'd4,
    PH_REPEAT_GAP = 3'd5
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_char;
    logic       button_raw;
  } item_t;

  typedef struct packed {
    logic             led_on;
    logic [1:0]       mode;
    logic [LEN_W-1:0] message_length;
    logic             press_seen;
  } result_t;

  // One letter's code: element count and a dash flag per element (element 0 first)
  typedef struct packed {
    logic [2:0] len;
    logic [3:0] dash;
  } code_t;

  function automatic logic [CLASS_W-1:0] char_class(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      d = c - 8'h41;
      return d[CLASS_W-1:0];
    end else if (c inside {[8'h61:8'h7A]}) begin
      d = c - 8'h61;
      return d[CLASS_W-1:0];
    end else if (c == CHAR_SPACE) begin
      return CLASS_SPACE;
    end
    return CLASS_OTHER;
  endfunction

  function automatic code_t morse_code(input logic [CLASS_W-1:0] letter);
    code_t c;
    case (letter)
      5'd0:    c = '{len: 3'd2, dash: 4'b0010}; // A
      5'd1:    c = '{len: 3'd4, dash: 4'b0001}; // B
      5'd2:    c = '{len: 3'd4, dash: 4'b0101}; // C
      5'd3:    c = '{len: 3'd3, dash: 4'b0001}; // D
      5'd4:    c = '{len: 3'd1, dash: 4'b0000}; // E
      5'd5:    c = '{len: 3'd4, dash: 4'b0100}; // F
      5'd6:    c = '{len: 3'd3, dash: 4'b0011}; // G
      5'd7:    c = '{len: 3'd4, dash: 4'b0000}; // H
      5'd8:    c = '{len: 3'd2, dash: 4'b0000}; // I
      5'd9:    c = '{len: 3'd4, dash: 4'b1110}; // J
      5'd10:   c = '{len: 3'd3, dash: 4'b0101}; // K
      5'd11:   c = '{len: 3'd4, dash: 4'b0010}; // L
      5'd12:   c = '{len: 3'd2, dash: 4'b0011}; // M
      5'd13:   c = '{len: 3'd2, dash: 4'b0001}; // N
      5'd14:   c = '{len: 3'd3, dash: 4'b0111}; // O
      5'd15:   c = '{len: 3'd4, dash: 4'b0110}; // P
      5'd16:   c = '{len: 3'd4, dash: 4'b1011}; // Q
      5'd17:   c = '{len: 3'd3, dash: 4'b0010}; // R
      5'd18:   c = '{len: 3'd3, dash: 4'b0000}; // S
      5'd19:   c = '{len: 3'd1, dash: 4'b0001}; // T
      5'd20:   c = '{len: 3'd3, dash: 4'b0100}; // U
      5'd21:   c = '{len: 3'd4, dash: 4'b1000}; // V
      5'd22:   c = '{len: 3'd3, dash: 4'b0110}; // W
      5'd23:   c = '{len: 3'd4, dash: 4'b1001}; // X
      5'd24:   c = '{len: 3'd4, dash: 4'b1101}; // Y
      5'd25:   c = '{len: 3'd4, dash: 4'b0011}; // Z
      default: c = '{len: 3'd0, dash: 4'b0000};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ sv/mbk_debounce.sv @@
// Button debouncer: settle counter and accepted level, flags a debounced press.
`default_nettype none

module mbk_debounce
  import mbk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  tick,
  input  wire logic                  raw,
  input  wire logic [DEBOUNCE_W-1:0] limit,
  output logic                       press
);

  logic                stable_button;
  logic                previous_raw;
  logic [SETTLE_W-1:0] settle_count;
  logic [SETTLE_W-1:0] settle_next;
  logic                take_level;

  always_comb begin
    if (raw != previous_raw) begin
      settle_next = '0;
    end else if (settle_count < SETTLE_MAX) begin
      settle_next = settle_count + SETTLE_W'(1);
    end else begin
      settle_next = settle_count;
    end
    take_level = (settle_next > SETTLE_W'(limit)) && (raw != stable_button);
    press      = tick && take_level && !raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_button <= 1'b1;
      previous_raw  <= 1'b1;
      settle_count  <= '0;
    end else if (tick) begin
      settle_count <= settle_next;
      previous_raw <= raw;
      if (take_level) begin
        stable_button <= raw;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/morse_beacon_keyer.sv @@
// Morse beacon keyer top level: message store, keying sequencer and result register.
`default_nettype none

// Each beat on the item channel is either a one-millisecond tick carrying the raw
// button level (func 0) or a received serial character (func 1), and each yields
// exactly one result beat with the key level, mode, stored length and a press flag
// for that item. A debounced press (the raw level going low, then held steady for
// more than debounce_ms ticks) empties the message and enters waiting mode,
// also during transmission. In waiting mode characters are stored up to 64;
// CR or LF with a non-empty message starts keying. Letters key dots of one unit
// and dashes of three units (dot_ms ticks per unit, zero taken as one), with one
// unit dark between elements, three after a letter, seven for a space and fourteen
// before the message repeats; other characters are counted but skipped in no time.
// Rate: one item per clock cycle, sustained while result_stall is low. Every item
// is handled in one pass of logic between the item channel and the result
// register, so its result is offered the cycle after acceptance; item_stall
// follows result_stall only while the result register is full. Only letters and
// spaces are kept in the internal store, as 5-bit class codes, which lets the
// sequencer step over the message one entry per phase; its read port is
// registered and always addresses the next read position. No clearing pass is needed after reset.

module morse_beacon_keyer
  import mbk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item channel
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire item_t                 item,
  // result channel
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic [DOT_W-1:0]      dot_ms;

  // Keyer state
  mode_t                 run_mode, run_mode_next;
  logic [CNT_W-1:0]      message_count, message_count_next;
  logic [CNT_W-1:0]      keep_count, keep_count_next;
  logic [CNT_W-1:0]      read_position, read_position_next;
  logic [1:0]            element_position, element_position_next;
  logic [TICKS_W-1:0]    phase_ticks, phase_ticks_next;
  phase_t                phase_kind, phase_kind_next;
  logic                  key_level, key_level_next;

  // Class store: letters and spaces only
  logic [CLASS_W-1:0]    class_store [MSG_DEPTH];
  logic [CLASS_W-1:0]    cur_class;
  logic                  store_we;
  logic [MSG_AW-1:0]     store_waddr;
  logic [CLASS_W-1:0]    store_wdata;

  // Handshake and item decode
  logic                  accept;
  logic                  tick;
  logic                  char_beat;
  logic                  press;
  logic [CLASS_W-1:0]    rx_class;
  logic [DOT_W-1:0]      unit_len;
  code_t                 cur_code;

  // Choice of the next phase when the current one has run out
  phase_t                pick_kind;
  logic [UNITS_W-1:0]    pick_units;
  logic                  pick_lit;
  logic [CNT_W-1:0]      pick_rp;
  logic [1:0]            pick_ep;
  logic [TICKS_W-1:0]    pick_ticks;
  logic [2:0]            next_elem;

  result_t               result_next;

  assign accept     = item_valid && !item_stall;
  assign tick       = accept && (item.func == FUNC_TICK);
  assign char_beat  = accept && (item.func == FUNC_CHAR);
  assign item_stall = result_valid && result_stall;
  assign rx_class   = char_class(item.rx_char);
  assign unit_len   = (dot_ms == '0) ? DOT_W'(1) : dot_ms;
  assign cur_code   = morse_code(cur_class);
  assign next_elem  = {1'b0, element_position} + 3'd1;

  mbk_debounce u_debounce (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .raw   (item.button_raw),
    .limit (debounce_ms),
    .press (press)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
      dot_ms      <= DOT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_ms <= cfg_data[DEBOUNCE_W-1:0];
        CFG_DOT:      dot_ms      <= cfg_data[DOT_W-1:0];
        default:      ;
      endcase
    end
  end

  // Next phase once the current one is spent (or keying has just started)
  always_comb begin
    pick_kind  = phase_kind;
    pick_units = UNITS_DOT;
    pick_lit   = 1'b0;
    pick_rp    = read_position;
    pick_ep    = element_position;
    case (phase_kind)
      PH_MARK: begin
        if (next_elem < cur_code.len) begin
          // more elements in this letter
          pick_ep    = next_elem[1:0];
          pick_kind  = PH_ELEM_GAP;
          pick_units = UNITS_ELEM_GAP;
        end else begin
          // letter done: advance past it
          pick_ep    = 2'd0;
          pick_rp    = read_position + CNT_W'(1);
          pick_kind  = PH_LETTER_GAP;
          pick_units = UNITS_LETTER_GAP;
        end
      end
      PH_ELEM_GAP: begin
        pick_kind  = PH_MARK;
        pick_units = cur_code.dash[element_position] ? UNITS_DASH : UNITS_DOT;
        pick_lit   = 1'b1;
      end
      default: begin
        // scan: the store holds only letters and spaces
        if (read_position < keep_count) begin
          if (cur_class == CLASS_SPACE) begin
            pick_rp    = read_position + CNT_W'(1);
            pick_kind  = PH_WORD_GAP;
            pick_units = UNITS_WORD_GAP;
          end else begin
            pick_ep    = 2'd0;
            pick_kind  = PH_MARK;
            pick_units = cur_code.dash[0] ? UNITS_DASH : UNITS_DOT;
            pick_lit   = 1'b1;
          end
        end else begin
          // end of message: long gap, then start over
          pick_rp    = '0;
          pick_kind  = PH_REPEAT_GAP;
          pick_units = UNITS_REPEAT_GAP;
        end
      end
    endcase
    pick_ticks = TICKS_W'(pick_units) * TICKS_W'(unit_len);
  end

  // Next state for the whole keyer
  always_comb begin
    run_mode_next         = run_mode;
    message_count_next    = message_count;
    keep_count_next       = keep_count;
    read_position_next    = read_position;
    element_position_next = element_position;
    phase_ticks_next      = phase_ticks;
    phase_kind_next       = phase_kind;
    key_level_next        = key_level;
    store_we              = 1'b0;
    store_waddr           = keep_count[MSG_AW-1:0];
    store_wdata           = rx_class;

    if (tick) begin
      if (press) begin
        // drop the message and stop keying
        run_mode_next         = MODE_WAIT;
        message_count_next    = '0;
        keep_count_next       = '0;
        read_position_next    = '0;
        element_position_next = 2'd0;
        phase_ticks_next      = '0;
        phase_kind_next       = PH_IDLE;
        key_level_next        = 1'b0;
      end else if (run_mode == MODE_SEND) begin
        if (phase_kind == PH_IDLE || phase_ticks == '0) begin
          read_position_next    = pick_rp;
          element_position_next = pick_ep;
          phase_kind_next       = pick_kind;
          key_level_next        = pick_lit;
          phase_ticks_next      = pick_ticks - TICKS_W'(1);
        end else begin
          phase_ticks_next = phase_ticks - TICKS_W'(1);
        end
      end
    end else if (char_beat && run_mode == MODE_WAIT) begin
      if (item.rx_char == CHAR_LF || item.rx_char == CHAR_CR) begin
        if (message_count != '0) begin
          run_mode_next         = MODE_SEND;
          read_position_next    = '0;
          element_position_next = 2'd0;
          phase_ticks_next      = '0;
          phase_kind_next       = PH_IDLE;
          key_level_next        = 1'b0;
        end
      end else if (message_count < CNT_W'(MSG_DEPTH)) begin
        message_count_next = message_count + CNT_W'(1);
        // keep only what takes keying time
        if (rx_class != CLASS_OTHER) begin
          store_we        = 1'b1;
          keep_count_next = keep_count + CNT_W'(1);
        end
      end
    end
  end

  // Result assembly from the state after this item
  always_comb begin
    result_next.led_on         = key_level_next;
    result_next.mode           = run_mode_next;
    result_next.message_length = LEN_W'(message_count_next);
    result_next.press_seen     = press;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode         <= MODE_START;
      message_count    <= '0;
      keep_count       <= '0;
      read_position    <= '0;
      element_position <= 2'd0;
      phase_ticks      <= '0;
      phase_kind       <= PH_IDLE;
      key_level        <= 1'b0;
    end else begin
      run_mode         <= run_mode_next;
      message_count    <= message_count_next;
      keep_count       <= keep_count_next;
      read_position    <= read_position_next;
      element_position <= element_position_next;
      phase_ticks      <= phase_ticks_next;
      phase_kind       <= phase_kind_next;
      key_level        <= key_level_next;
    end
  end

  // Store write; the read follows the next read position so the class is ready
  always_ff @(posedge clk) begin
    if (store_we) begin
      class_store[store_waddr] <= store_wdata;
    end
  end

  always_ff @(posedge clk) begin
    cur_class <= class_store[read_position_next[MSG_AW-1:0]];
  end

  // Result register: load on every accepted beat, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  // Key only lit during a mark
  a_lit_in_mark: assert property (@(posedge clk) disable iff (rst)
    key_level |-> (phase_kind == PH_MARK))
    else $error("key lit outside a mark phase");

  // Keying runs only while transmitting
  a_idle_unless_send: assert property (@(posedge clk) disable iff (rst)
    (run_mode != MODE_SEND) |-> (phase_kind == PH_IDLE && !key_level))
    else $error("keying active outside transmit mode");

  // Kept entries never outnumber stored characters, nor does the read position
  a_counts: assert property (@(posedge clk) disable iff (rst)
    (keep_count <= message_count) && (read_position <= keep_count))
    else $error("store counters out of order");

  // A press result always shows an empty message in waiting mode
  a_press_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.press_seen) |->
      (result.mode == MODE_WAIT && result.message_length == '0 && !result.led_on))
    else $error("press result with wrong mode or length");

endmodule

`default_nettype wire

@@ verif/morse_beacon_keyer_test.sv @@
// Self-checking testbench for the Morse beacon keyer: random ticks and characters against a predictor.
`timescale 1ns / 1ps

module morse_beacon_keyer_test;
  import mbk_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 40;
  localparam int KEY_TICK_CAP = 400;
  localparam int KEY_TICK_MIN = 40;

  localparam logic [7:0] UPPER_A  = "A";
  localparam logic [7:0] UPPER_Z  = "Z";
  localparam logic [7:0] LOWER_A  = "a";
  localparam logic [7:0] LOWER_Z  = "z";
  localparam logic [7:0] DASH_SYM = "-";

  // Clock, reset and the pins of the block; every input starts at a known level
  logic    clk;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_stall;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  morse_beacon_keyer dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Keyer predictor: a private copy of the registers and of the keying state.
  // It is stepped once for every item beat taken by the block.
  // ---------------------------------------------------------------------------
  int              debounce_cfg;
  int              dot_cfg;
  mode_t           km_mode;
  logic [7:0]      msg_bytes [MSG_DEPTH];
  logic [CNT_W-1:0] msg_count;
  logic            stable_lvl;
  logic            prev_raw;
  int              settle;
  int              rd_pos;
  int              el_pos;
  int              ph_ticks;
  phase_t          ph_kind;
  logic            key_lit;

  // Run statistics for the closing summary
  int presses_seen;
  int sends_started;
  int marks_keyed;
  int settings_run;

  function automatic string morse_of(int letter);
    case (letter)
      0:  morse_of = ".-";    1:  morse_of = "-...";  2:  morse_of = "-.-.";
      3:  morse_of = "-..";   4:  morse_of = ".";     5:  morse_of = "..-.";
      6:  morse_of = "--.";   7:  morse_of = "....";  8:  morse_of = "..";
      9:  morse_of = ".---";  10: morse_of = "-.-";   11: morse_of = ".-..";
      12: morse_of = "--";    13: morse_of = "-.";    14: morse_of = "---";
      15: morse_of = ".--.";  16: morse_of = "--.-";  17: morse_of = ".-.";
      18: morse_of = "...";   19: morse_of = "-";     20: morse_of = "..-";
      21: morse_of = "...-";  22: morse_of = ".--";   23: morse_of = "-..-";
      24: morse_of = "-.--";  25: morse_of = "--..";
      default: morse_of = "";
    endcase
  endfunction

  // Letter index 0..25, then space, then anything else
  function automatic int class_of(logic [7:0] c);
    if (c >= UPPER_A && c <= UPPER_Z) return int'(c) - int'(UPPER_A);
    if (c >= LOWER_A && c <= LOWER_Z) return int'(c) - int'(LOWER_A);
    if (c == CHAR_SPACE) return int'(CLASS_SPACE);
    return int'(CLASS_OTHER);
  endfunction

  function automatic int symbol_at(int pos);
    if (pos < MSG_DEPTH) return class_of(msg_bytes[pos[MSG_AW-1:0]]);
    return int'(CLASS_OTHER);
  endfunction

  function automatic void load_phase(phase_t kind, int units, logic lit);
    ph_kind  = kind;
    ph_ticks = units * ((dot_cfg == 0) ? 1 : dot_cfg);
    key_lit  = lit;
  endfunction

  function automatic void begin_mark();
    string code;
    code = morse_of(symbol_at(rd_pos));
    marks_keyed++;
    if (el_pos < code.len() && code[el_pos] == DASH_SYM)
      load_phase(PH_MARK, int'(UNITS_DASH), 1'b1);
    else load_phase(PH_MARK, int'(UNITS_DOT), 1'b1);
  endfunction

  // Step over skipped characters to the next letter or space, or wrap round
  function automatic void seek_symbol();
    int k;
    while (rd_pos < msg_count && rd_pos < MSG_DEPTH) begin
      k = symbol_at(rd_pos);
      if (k < CLASS_SPACE) begin
        el_pos = 0;
        begin_mark();
        return;
      end
      rd_pos++;
      if (k == CLASS_SPACE) begin
        load_phase(PH_WORD_GAP, int'(UNITS_WORD_GAP), 1'b0);
        return;
      end
    end
    rd_pos = 0;
    load_phase(PH_REPEAT_GAP, int'(UNITS_REPEAT_GAP), 1'b0);
  endfunction

  function automatic void advance_phase();
    string code;
    if (ph_kind == PH_MARK) begin
      code = morse_of(symbol_at(rd_pos));
      if (el_pos + 1 < code.len()) begin
        el_pos++;
        load_phase(PH_ELEM_GAP, int'(UNITS_ELEM_GAP), 1'b0);
      end else begin
        el_pos = 0;
        rd_pos++;
        load_phase(PH_LETTER_GAP, int'(UNITS_LETTER_GAP), 1'b0);
      end
    end else if (ph_kind == PH_ELEM_GAP) begin
      begin_mark();
    end else begin
      seek_symbol();
    end
  endfunction

  function automatic void stop_keying();
    rd_pos   = 0;
    el_pos   = 0;
    ph_ticks = 0;
    ph_kind  = PH_IDLE;
    key_lit  = 1'b0;
  endfunction

  function automatic void keyer_reset();
    debounce_cfg = int'(DEBOUNCE_RESET);
    dot_cfg      = int'(DOT_RESET);
    km_mode      = MODE_START;
    foreach (msg_bytes[i]) msg_bytes[i] = 8'h00;
    msg_count    = '0;
    stable_lvl   = 1'b1;
    prev_raw     = 1'b1;
    settle       = 0;
    stop_keying();
  endfunction

  function automatic result_t keyer_step(item_t it);
    logic    press;
    result_t r;
    press = 1'b0;
    if (it.func == FUNC_TICK) begin
      if (it.button_raw != prev_raw) settle = 0;
      else if (settle < SETTLE_MAX) settle++;
      if (settle > debounce_cfg && it.button_raw != stable_lvl) begin
        stable_lvl = it.button_raw;
        press = !it.button_raw;
      end
      prev_raw = it.button_raw;
      if (press) begin
        km_mode   = MODE_WAIT;
        msg_count = '0;
        stop_keying();
        presses_seen++;
      end
      if (km_mode == MODE_SEND) begin
        if (ph_kind == PH_IDLE || ph_ticks == 0) advance_phase();
        if (ph_ticks > 0) ph_ticks--;
      end
    end else if (km_mode == MODE_WAIT) begin
      if (it.rx_char == CHAR_LF || it.rx_char == CHAR_CR) begin
        if (msg_count != 0) begin
          km_mode = MODE_SEND;
          stop_keying();
          sends_started++;
        end
      end else if (msg_count < MSG_DEPTH) begin
        msg_bytes[msg_count[MSG_AW-1:0]] = it.rx_char;
        msg_count++;
      end
    end
    r.led_on         = key_lit;
    r.mode           = km_mode;
    r.message_length = msg_count;
    r.press_seen     = press;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and idle-gap drawing shared by both channel processes
  // ---------------------------------------------------------------------------
  item_t   pending_items [$];
  result_t expected_results [$];
  int      planned;

  // Mostly back to back, some short gaps, a few long ones, and now and then a
  // calm stretch with no gaps at all
  task automatic draw_gap(inout int calm, output int gap);
    int r;
    gap = 0;
    if (calm > 0) begin
      calm--;
    end else begin
      r = $urandom_range(0, 199);
      if (r == 0) calm = $urandom_range(40, 160);
      else if (r >= 130 && r < 190) gap = $urandom_range(1, 3);
      else if (r >= 190) gap = $urandom_range(8, 40);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: offers beats from the pending queue on the falling edge and
  // holds each one steady until the block takes it.
  // ---------------------------------------------------------------------------
  logic beat_taken = 1'b0;
  int   send_gap   = 0;
  int   send_calm  = 0;

  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (item_valid && !beat_taken) begin
      // hold: the offered beat is still waiting on item_stall
    end else if (send_gap > 0) begin
      send_gap--;
      item_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      item       <= pending_items.pop_front();
      item_valid <= 1'b1;
      draw_gap(send_calm, send_gap);
    end else begin
      item_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall on the falling edge. Once, while plenty of
  // items are still pending, hold off for a long stretch so the result
  // register fills and the block has to stall its item channel.
  // ---------------------------------------------------------------------------
  int hold_left     = 0;
  int stall_left    = 0;
  int stall_calm    = 0;
  bit pressure_done = 1'b0;
  int items_in      = 0;
  int results_in    = 0;

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (!pressure_done && items_in > 100 && pending_items.size() > 50) begin
      pressure_done = 1'b1;
      hold_left     = LONG_HOLD - 1;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      draw_gap(stall_calm, stall_left);
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: on the rising edge, step the predictor for each item beat taken
  // and compare each result beat with the oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  int      mismatches = 0;
  result_t want;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at result beat %0d: %s", results_in, what);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall) begin
        expected_results.push_back(keyer_step(item));
        items_in++;
      end
      if (result_valid && !result_stall) begin
        results_in++;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          if (result.led_on !== want.led_on)
            report_mismatch($sformatf("led_on %b, predicted %b", result.led_on, want.led_on));
          if (result.mode !== want.mode)
            report_mismatch($sformatf("mode %0d, predicted %0d", result.mode, want.mode));
          if (result.message_length !== want.message_length)
            report_mismatch($sformatf("message_length %0d, predicted %0d",
                                      result.message_length, want.message_length));
          if (result.press_seen !== want.press_seen)
            report_mismatch($sformatf("press_seen %b, predicted %b",
                                      result.press_seen, want.press_seen));
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here
  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders: they only fill the pending queue and take no time
  // ---------------------------------------------------------------------------
  function automatic item_t tick_item(logic raw);
    item_t it;
    it.func       = FUNC_TICK;
    it.rx_char    = 8'($urandom_range(0, 255));
    it.button_raw = raw;
    return it;
  endfunction

  function automatic item_t char_item(logic [7:0] c);
    item_t it;
    it.func       = FUNC_CHAR;
    it.rx_char    = c;
    it.button_raw = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task automatic queue_item(item_t it, bit counts);
    pending_items.push_back(it);
    if (counts) planned++;
  endtask

  task automatic add_ticks(int n, logic raw);
    repeat (n) queue_item(tick_item(raw), 1'b1);
  endtask

  // Random message character; plain ones are neither letters nor space.
  // CR and LF never appear inside a message.
  function automatic logic [7:0] pick_char(bit plain);
    logic [7:0] c;
    int r;
    r = $urandom_range(0, 99);
    if (!plain && r < 45) return 8'(UPPER_A + $urandom_range(0, 25));
    if (!plain && r < 70) return 8'(LOWER_A + $urandom_range(0, 25));
    if (!plain && r < 85) return CHAR_SPACE;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CHAR_CR || c == CHAR_LF || (plain && class_of(c) != CLASS_OTHER));
    return c;
  endfunction

  function automatic logic [7:0] pick_terminator();
    return $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
  endfunction

  // Settle released, hold pressed long enough to count, then settle released
  task automatic add_press();
    add_ticks(debounce_cfg + 2 + $urandom_range(0, 3), 1'b1);
    add_ticks(debounce_cfg + 2 + $urandom_range(0, 3), 1'b0);
    add_ticks(debounce_cfg + 2 + $urandom_range(0, 3), 1'b1);
  endtask

  // Released ticks that drive the keying, with one-tick bounces that never
  // pass the debounce and characters that transmission must drop
  task automatic add_keying(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        add_ticks(1, 1'b0);
        add_ticks(1, 1'b1);
        i++;
      end else if (r < 5) begin
        queue_item(char_item(8'($urandom_range(0, 255))), 1'b1);
      end else begin
        add_ticks(1, 1'b1);
      end
    end
  endtask

  // One well-formed exchange: press, message, end of line, keying; the keying
  // stretch is trimmed to what is left of the budget
  task automatic add_session(int room);
    int  r;
    int  n;
    int  unit;
    bit  plain;
    r     = $urandom_range(0, 99);
    plain = (r >= 20 && r < 30);
    unit  = (dot_cfg == 0) ? 1 : dot_cfg;
    add_press();
    // end of line on an empty store does nothing
    if (r < 10) queue_item(char_item(pick_terminator()), 1'b1);
    // overfill the store now and then; the extras are dropped
    if (r >= 10 && r < 20) n = MSG_DEPTH + $urandom_range(1, 4);
    else n = $urandom_range(1, 8);
    repeat (n) queue_item(char_item(pick_char(plain)), 1'b1);
    queue_item(char_item(pick_terminator()), 1'b1);
    n = $urandom_range(20, 160) * unit;
    if (n > KEY_TICK_CAP) n = KEY_TICK_CAP;
    if (n > room) n = (room > KEY_TICK_MIN) ? room : KEY_TICK_MIN;
    add_keying(n);
  endtask

  // Unstructured beats in any mode; not counted towards the item budget
  task automatic add_noise(int n);
    repeat (n) begin
      if ($urandom_range(0, 1)) queue_item(tick_item(1'($urandom_range(0, 1))), 1'b0);
      else if ($urandom_range(0, 9) == 0) queue_item(char_item(pick_terminator()), 1'b0);
      else queue_item(char_item(8'($urandom_range(0, 255))), 1'b0);
    end
  endtask

  // Short directed opening with the fastest debounce and unit
  task automatic queue_directed();
    queue_item(char_item(UPPER_A), 1'b0);    // still starting: dropped
    queue_item(char_item(CHAR_LF), 1'b0);    // still starting: ignored
    queue_item(tick_item(1'b1), 1'b0);
    queue_item(tick_item(1'b0), 1'b0);
    queue_item(tick_item(1'b0), 1'b0);       // press after a single steady tick
    queue_item(tick_item(1'b1), 1'b0);
    queue_item(tick_item(1'b1), 1'b0);       // release accepted
    queue_item(char_item(CHAR_CR), 1'b0);    // empty store: ignored
    queue_item(char_item(LOWER_A), 1'b0);
    queue_item(char_item(UPPER_Z), 1'b0);
    queue_item(char_item(CHAR_SPACE), 1'b0);
    queue_item(char_item(8'hFF), 1'b0);      // skipped when keyed
    queue_item(char_item(8'h00), 1'b0);
    queue_item(char_item(LOWER_Z), 1'b0);
    queue_item(char_item(CHAR_LF), 1'b0);    // start sending
    repeat (6) queue_item(tick_item(1'b1), 1'b0);
    queue_item(char_item(UPPER_Z), 1'b0);    // sending: dropped
    queue_item(tick_item(1'b0), 1'b0);
    queue_item(tick_item(1'b0), 1'b0);       // press aborts the transmission
    queue_item(tick_item(1'b1), 1'b0);
    queue_item(tick_item(1'b1), 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing: registers change only with nothing in flight
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    // bits above the debounce field are junk the block must drop
    if (idx == CFG_DEBOUNCE) data[CFG_DATA_W-1:DEBOUNCE_W] = 2'($urandom_range(0, 3));
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_DEBOUNCE) debounce_cfg = int'(data[DEBOUNCE_W-1:0]);
    else dot_cfg = int'(data[DOT_W-1:0]);
  endtask

  task automatic run_phase(int debounce, int dot, int budget);
    int start;
    wait_idle();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_DOT, dot);
    settings_run++;
    @(posedge clk);
    start = planned;
    while (planned - start < budget) begin
      if ($urandom_range(0, 99) < 80) add_session(budget - (planned - start));
      else add_noise($urandom_range(4, 20));
    end
  endtask

  // Slowest debounce: a press held far shorter than the limit is ignored
  task automatic run_slow_debounce();
    wait_idle();
    write_reg(CFG_DEBOUNCE, 1023);
    write_reg(CFG_DOT, 3);
    settings_run++;
    @(posedge clk);
    add_ticks(40, 1'b0);
    add_ticks(40, 1'b1);
  endtask

  initial begin
    planned       = 0;
    presses_seen  = 0;
    sends_started = 0;
    marks_keyed   = 0;
    settings_run  = 0;
    keyer_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_reg(CFG_DEBOUNCE, 0);
    write_reg(CFG_DOT, 1);
    settings_run++;
    @(posedge clk);
    queue_directed();

    run_phase(0, 1, 220);
    run_phase(3, 2, 180);
    run_phase(1, 0, 120);                       // zero unit, keyed as one tick
    run_phase(2, 4095, 1);                      // longest unit
    run_slow_debounce();
    run_phase(int'(DEBOUNCE_RESET), int'(DOT_RESET), 1);    // back to the power-up values
    run_phase($urandom_range(0, 7), $urandom_range(1, 6), 150);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Ran %0d item beats and %0d result beats over %0d register settings.",
             items_in, results_in, settings_run);
    $display("Debounced presses %0d, transmissions %0d, marks keyed %0d, long hold-off %0d.",
             presses_seen, sends_started, marks_keyed, pressure_done);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
